// ===== rtl/stf_pkg.sv =====
// Shared types and constants for the section tag run finder.
package stf_pkg;

    typedef logic [7:0] t_byte;

    // Record layout: zero byte, three tag characters, end mark, three free bytes.
    localparam int REC_BYTES = 8;
    localparam int SEARCH_MARGIN = 32;

    localparam t_byte REC_HEAD = 8'h00;
    localparam t_byte REC_END_MARK = 8'h01;
    localparam t_byte PRINT_LO = 8'h20;
    localparam t_byte PRINT_HI = 8'h7e;

    localparam int N_TAGS = 6;
    localparam logic [23:0] TAGS [N_TAGS] = '{"GFX", "JMA", "PRG", "SCA", "RY ", "---"};

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_FLUSH = 3'b010,
        S_DONE  = 3'b100
    } t_state;

endpackage

// ===== rtl/stf_rec_cell.sv =====
// One record-wide cell of the byte window chain with its own record check.
module stf_rec_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  stf_pkg::t_byte i_byte,
    input  logic          i_valid,
    output stf_pkg::t_byte o_head,
    output logic          o_head_valid,
    output logic          o_ok
);
    import stf_pkg::*;

    t_byte                r_bytes [REC_BYTES];
    logic [REC_BYTES-1:0] r_vld;    // bit 0 oldest byte

    function automatic logic printable(t_byte c);
        return (c >= PRINT_LO) && (c <= PRINT_HI);
    endfunction

    function automatic logic record_ok(t_byte b0, t_byte b1, t_byte b2, t_byte b3, t_byte b4);
        logic hit;
        hit = 1'b0;
        for (int t = 0; t < N_TAGS; t++) begin
            if ({b1, b2, b3} == TAGS[t]) begin
                hit = 1'b1;
            end
        end
        return (b0 == REC_HEAD) && (b4 == REC_END_MARK) &&
               printable(b1) && printable(b2) && printable(b3) && hit;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < REC_BYTES - 1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
            r_bytes[REC_BYTES-1] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_shift) begin
            r_vld <= {i_valid, r_vld[REC_BYTES-1:1]};
        end
    end

    assign o_head       = r_bytes[0];
    assign o_head_valid = r_vld[0];
    // a record counts only when its last byte is real stream data
    assign o_ok = r_vld[REC_BYTES-1] &&
                  record_ok(r_bytes[0], r_bytes[1], r_bytes[2], r_bytes[3], r_bytes[4]);

endmodule

// ===== rtl/stf_run_judge.sv =====
// Counts leading good records of the cell chain and tests the minimum run.
module stf_run_judge #(
    parameter int N_REC   = 6,
    parameter int MIN_RUN = 4
) (
    input  logic [N_REC-1:0] i_ok,
    output logic             o_hit,
    output logic [2:0]       o_count
);
    localparam int CW = $clog2(N_REC + 1);

    logic [CW-1:0] cnt;

    always_comb begin
        logic run;
        run = 1'b1;
        cnt = '0;
        for (int k = 0; k < N_REC; k++) begin
            run = run & i_ok[k];
            cnt = cnt + CW'(run);
        end
    end

    assign o_hit   = (cnt >= CW'(MIN_RUN));
    assign o_count = (cnt > CW'(7)) ? 3'd7 : 3'(cnt);

endmodule

// ===== rtl/section_tag_run_finder_core.sv =====
// Top level of the section tag run finder: byte window chain, judge and control.
//
// Usage: a file streams in one byte per request on the slave side
// (i_s_tdata = byte, i_s_tlast marks the final byte). While the stream runs a
// byte is taken every cycle. Once the window holds MAX_RUN records past a
// candidate offset, that offset is judged in the cycle after its byte.
// After the final byte the block flushes the still pending offsets, one per
// cycle, by shifting the cell chain with padding, cut short once a run is
// latched. The result then moves into the output register as soon as that
// register is free; the input is held off during flush and until the result
// has moved into the output register.
// Each stream gives exactly one result request on the master side:
// o_m_tuser = found, o_m_tdata = offset and count, zero when nothing found.
// The output register decouples the sides: a new stream may start while the
// result still waits; if the receiver stalls, the next stream's result waits
// at the end of its flush until the register is free.
// Reset (synchronous, active low) clears the control state, the run latch
// and the byte-valid flags; the window data needs no clear.
module section_tag_run_finder_core #(
    parameter int MAX_RUN = 6,
    parameter int MIN_RUN = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave side
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  stf_pkg::t_byte i_s_tdata,    // [7:0] data_byte
    input  logic          i_s_tlast,    // last_byte
    // master side
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,    // [31:0] run_offset, [34:32] run_count, rest 0
    output logic          o_m_tuser     // [0] found
);
    import stf_pkg::*;

    localparam int WIN     = MAX_RUN * REC_BYTES;
    localparam int FLUSH_N = WIN - SEARCH_MARGIN;
    localparam int J_W     = (FLUSH_N > 1) ? $clog2(FLUSH_N) : 1;

    t_state        r_state, n_state;
    logic [31:0]   r_n;          // bytes taken in this stream
    logic          r_eval;       // full-window candidate waits to be judged
    logic [31:0]   r_eoff;
    logic [32:0]   r_foff;       // flush candidate offset, negative before stream start
    logic [J_W-1:0] r_j;
    logic          r_latched;
    logic [31:0]   r_moff;
    logic [2:0]    r_mcount;
    logic          r_ovalid;
    logic          r_ofound;
    logic [31:0]   r_ooff;
    logic [2:0]    r_ocnt;

    logic          s_acc;
    logic          shift;
    t_byte         shift_byte;
    logic          out_free;
    logic          try_normal;
    logic          try_flush;
    logic          take;
    logic          j_hit;
    logic [2:0]    j_count;
    logic          flush_end;

    t_byte             head_byte [MAX_RUN];
    logic [MAX_RUN-1:0] head_vld;
    logic [MAX_RUN-1:0] rec_ok;

    assign o_s_tready = (r_state == S_RUN);
    assign s_acc      = i_s_tvalid && o_s_tready;
    // flush shifts padding in, marked not valid
    assign shift      = s_acc || (r_state == S_FLUSH);
    assign shift_byte = s_acc ? i_s_tdata : t_byte'(0);
    assign out_free   = !r_ovalid || i_m_tready;

    // cell 0 holds the oldest record; new bytes enter the last cell
    for (genvar k = 0; k < MAX_RUN; k++) begin : g_cell
        stf_rec_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_byte       ((k == MAX_RUN - 1) ? shift_byte : head_byte[(k + 1) % MAX_RUN]),
            .i_valid      ((k == MAX_RUN - 1) ? s_acc : head_vld[(k + 1) % MAX_RUN]),
            .o_head       (head_byte[k]),
            .o_head_valid (head_vld[k]),
            .o_ok         (rec_ok[k])
        );
    end

    stf_run_judge #(
        .N_REC   (MAX_RUN),
        .MIN_RUN (MIN_RUN)
    ) u_judge (
        .i_ok    (rec_ok),
        .o_hit   (j_hit),
        .o_count (j_count)
    );

    // lowest offset wins: candidates come in order and stop once latched
    assign try_normal = r_eval && !r_latched;
    assign try_flush  = (r_state == S_FLUSH) && !r_latched && !r_foff[32];
    assign take       = (try_normal || try_flush) && j_hit;
    assign flush_end  = (r_j == J_W'(FLUSH_N - 1)) || take || r_latched;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (s_acc && i_s_tlast) begin
                    n_state = (FLUSH_N > 0) ? S_FLUSH : S_DONE;
                end
            end
            S_FLUSH: begin
                if (flush_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_n       <= '0;
            r_eval    <= 1'b0;
            r_j       <= '0;
            r_latched <= 1'b0;
            r_moff    <= '0;
            r_mcount  <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= s_acc && !i_s_tlast && (r_n >= 32'(WIN - 1));

            if (s_acc) begin
                r_n <= r_n + 32'd1;
            end
            if (s_acc && i_s_tlast) begin
                r_j <= '0;
            end else if (r_state == S_FLUSH) begin
                r_j <= r_j + J_W'(1);
            end

            if (take) begin
                r_latched <= 1'b1;
                r_moff    <= try_flush ? r_foff[31:0] : r_eoff;
                r_mcount  <= j_count;
            end

            if (r_state == S_DONE && out_free) begin
                r_ovalid  <= 1'b1;
                r_latched <= 1'b0;
                r_moff    <= '0;
                r_mcount  <= '0;
                r_n       <= '0;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_eoff <= r_n - 32'(WIN - 1);
        end
        if (s_acc && i_s_tlast) begin
            r_foff <= {1'b0, r_n} - 33'(WIN - 1);
        end else if (r_state == S_FLUSH) begin
            r_foff <= r_foff + 33'd1;
        end
        if (r_state == S_DONE && out_free) begin
            r_ofound <= r_latched;
            r_ooff   <= r_latched ? r_moff : 32'd0;
            r_ocnt   <= r_latched ? r_mcount : 3'd0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ofound;
    assign o_m_tdata  = {5'd0, r_ocnt, r_ooff};

    a_last_leaves_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (r_state != S_RUN))
        else $error("last byte did not start the flush");

    a_latch_min_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |-> (r_mcount >= 3'(MIN_RUN)))
        else $error("latched run shorter than minimum");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 40'd0))
        else $error("empty result carries data");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (!r_latched && r_n == 32'd0))
        else $error("stream state not cleared after result");

endmodule
